>>> design/hslrgb_pkg.sv
// Shared constants and types of the HSL to RGB converter.
`default_nettype none

package hslrgb_pkg;

  // Default fraction width of the fixed-point datapath
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Fixed port widths
  localparam int unsigned IN_W  = 18;
  localparam int unsigned OUT_W = 8;

  // Channel lanes
  localparam int unsigned CH_N     = 3;
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  // Cycles from an accepted transaction to its result strobe
  localparam int unsigned LATENCY = 6;

  // Segment of the piecewise hue ramp
  typedef enum logic [1:0] {
    SEG_RISE,   // p + d * 6t
    SEG_HIGH,   // q
    SEG_FALL,   // p + d * 6(2/3 - t)
    SEG_LOW     // p
  } seg_e;

  // Control that travels with each pipeline stage
  typedef struct packed {
    logic valid;
    logic grey;
  } ctl_t;

endpackage

`default_nettype wire

>>> design/hsl_to_rgb_converter.sv
// Top level of the pipelined HSL to RGB converter.
//
// Usage: drive hue_i, saturation_i and lightness_i (signed, FRAC_BITS
// fraction bits, clamped to 0..1 internally) and raise start_i for one
// cycle per transaction. A transaction is taken at every rising edge with
// start_i high and busy_o low; busy_o stays low, so one pixel can enter
// on every clock.
// Result: red_o, green_o and blue_o show the 8-bit channels for exactly one
// cycle, marked by done_o.
// Throughput is one transaction per cycle; each result passes through the
// stage chain clamp/wrap, q product, q/p, ramp product, select, scale.
// Results leave in the order the transactions came in.
// Reset (rst_ni low, asynchronous) clears all valid bits; transactions in
// flight are dropped and no strobe follows. The receiver cannot stall, so
// the pipeline never holds.
`default_nettype none

module hsl_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = hslrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [hslrgb_pkg::IN_W-1:0]    hue_i,
  input  logic signed [hslrgb_pkg::IN_W-1:0]    saturation_i,
  input  logic signed [hslrgb_pkg::IN_W-1:0]    lightness_i,
  output logic                                  done_o,
  output logic [hslrgb_pkg::OUT_W-1:0]          red_o,
  output logic [hslrgb_pkg::OUT_W-1:0]          green_o,
  output logic [hslrgb_pkg::OUT_W-1:0]          blue_o
);
  import hslrgb_pkg::*;

  localparam int unsigned W = FRAC_BITS + 1;

  // Fully pipelined: never refuses a transaction
  logic take;
  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;

  // Stages 1-2
  ctl_t                   ctl2;
  logic [W-1:0]           l2, s2;
  logic                   low_half2;
  logic [2*FRAC_BITS+2:0] prod2;
  seg_e [CH_N-1:0]        seg2;
  logic [CH_N-1:0][W-1:0] fac2;

  hslrgb_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (take),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .ctl_o        (ctl2),
    .l_o          (l2),
    .s_o          (s2),
    .low_half_o   (low_half2),
    .prod_o       (prod2),
    .seg_o        (seg2),
    .fac_o        (fac2)
  );

  // Stage 3
  ctl_t                   ctl3;
  logic [W-1:0]           l3, p3, q3, d3;
  seg_e [CH_N-1:0]        seg3;
  logic [CH_N-1:0][W-1:0] fac3;

  hslrgb_qp #(.FRAC_BITS(FRAC_BITS)) u_qp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl2),
    .l_i        (l2),
    .s_i        (s2),
    .low_half_i (low_half2),
    .prod_i     (prod2),
    .seg_i      (seg2),
    .fac_i      (fac2),
    .ctl_o      (ctl3),
    .l_o        (l3),
    .p_o        (p3),
    .q_o        (q3),
    .d_o        (d3),
    .seg_o      (seg3),
    .fac_o      (fac3)
  );

  // Stages 4-6, one lane per channel
  logic [CH_N-1:0]            lane_valid;
  logic [CH_N-1:0][OUT_W-1:0] lane_value;

  for (genvar c = 0; c < CH_N; c++) begin : g_chan
    hslrgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl3),
      .seg_i   (seg3[c]),
      .fac_i   (fac3[c]),
      .l_i     (l3),
      .p_i     (p3),
      .q_i     (q3),
      .d_i     (d3),
      .valid_o (lane_valid[c]),
      .value_o (lane_value[c])
    );
  end

  assign done_o  = lane_valid[CH_RED];
  assign red_o   = lane_value[CH_RED];
  assign green_o = lane_value[CH_GREEN];
  assign blue_o  = lane_value[CH_BLUE];

  // Every taken transaction is followed by its result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##LATENCY done_o)
    else $error("result strobe missing");

  // No result strobe without an earlier taken transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(take, LATENCY))
    else $error("spurious result strobe");

  // The three channel lanes stay in lockstep
  a_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_valid[CH_GREEN] == lane_valid[CH_RED]) &&
    (lane_valid[CH_BLUE] == lane_valid[CH_RED]))
    else $error("channel lanes out of step");

endmodule

`default_nettype wire

>>> design/hslrgb_prep.sv
// Input conditioning: clamp, hue offsets and wrap, q product and ramp factors.
`default_nettype none

module hslrgb_prep #(
  parameter int unsigned FRAC_BITS = hslrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            valid_i,
  input  logic signed [hslrgb_pkg::IN_W-1:0]              hue_i,
  input  logic signed [hslrgb_pkg::IN_W-1:0]              saturation_i,
  input  logic signed [hslrgb_pkg::IN_W-1:0]              lightness_i,
  output hslrgb_pkg::ctl_t                                ctl_o,
  output logic [FRAC_BITS:0]                              l_o,
  output logic [FRAC_BITS:0]                              s_o,
  output logic                                            low_half_o,
  output logic [2*FRAC_BITS+2:0]                          prod_o,
  output hslrgb_pkg::seg_e [hslrgb_pkg::CH_N-1:0]         seg_o,
  output logic [hslrgb_pkg::CH_N-1:0][FRAC_BITS:0]        fac_o
);
  import hslrgb_pkg::*;

  localparam int unsigned W     = FRAC_BITS + 1;
  localparam int unsigned MW    = FRAC_BITS + 2;
  localparam int unsigned PW    = 2 * FRAC_BITS + 3;
  localparam int unsigned CW    = ((IN_W > W) ? IN_W : W) + 1;
  localparam int unsigned ONE_I = 1 << FRAC_BITS;

  localparam logic [W-1:0] ONE        = W'(ONE_I);
  localparam logic [W-1:0] HALF       = W'(ONE_I / 2);
  localparam logic [W-1:0] THIRD      = W'(ONE_I / 3);
  localparam logic [W-1:0] SIXTH      = W'(ONE_I / 6);
  localparam logic [W-1:0] TWO_THIRDS = W'((2 * ONE_I) / 3);

  // Clamp a signed input to 0..ONE
  function automatic logic [W-1:0] clamp_in(input logic signed [IN_W-1:0] v);
    logic signed [CW-1:0] x;
    logic [W-1:0]         r;
    x = CW'(v);
    if (x < 0) begin
      r = '0;
    end else if (x > $signed(CW'(ONE))) begin
      r = ONE;
    end else begin
      r = x[W-1:0];
    end
    return r;
  endfunction

  // Stage 1: clamp and hue offsets
  logic [W-1:0]             h_c, s_c, l_c;
  logic [W:0]               tr_sum;
  logic [W:0]               tr_wrap;
  logic [CH_N-1:0][W-1:0]   t_d;

  always_comb begin
    h_c     = clamp_in(hue_i);
    s_c     = clamp_in(saturation_i);
    l_c     = clamp_in(lightness_i);
    tr_sum  = (W+1)'(h_c) + (W+1)'(THIRD);
    tr_wrap = tr_sum - (W+1)'(ONE);
    t_d[CH_RED]   = (tr_sum > (W+1)'(ONE)) ? tr_wrap[W-1:0] : tr_sum[W-1:0];
    t_d[CH_GREEN] = h_c;
    t_d[CH_BLUE]  = (h_c < THIRD) ? (h_c + (ONE - THIRD)) : (h_c - THIRD);
  end

  ctl_t                   ctl1_q;
  logic [W-1:0]           l1_q, s1_q;
  logic [CH_N-1:0][W-1:0] t1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else begin
      ctl1_q.valid <= valid_i;
      ctl1_q.grey  <= (s_c == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    l1_q <= l_c;
    s1_q <= s_c;
    t1_q <= t_d;
  end

  // Stage 2: l * (1 + s) or l * s, ramp segment and factor per channel
  logic                   low_half_d;
  logic [MW-1:0]          mul_b;
  logic [PW-1:0]          prod_d;
  seg_e [CH_N-1:0]        seg_d;
  logic [CH_N-1:0][W-1:0] fac_d;
  logic [W+2:0]           six_t;

  always_comb begin
    low_half_d = (l1_q < HALF);
    mul_b      = low_half_d ? (MW'(ONE) + MW'(s1_q)) : MW'(s1_q);
    prod_d     = PW'(l1_q) * PW'(mul_b);
    six_t      = '0;
    for (int i = 0; i < CH_N; i++) begin
      if (t1_q[i] < SIXTH) begin
        seg_d[i] = SEG_RISE;
        six_t    = (W+3)'(t1_q[i]) * (W+3)'(6);
        fac_d[i] = six_t[W-1:0];
      end else if (t1_q[i] < HALF) begin
        seg_d[i] = SEG_HIGH;
        fac_d[i] = '0;
      end else if (t1_q[i] < TWO_THIRDS) begin
        seg_d[i] = SEG_FALL;
        six_t    = (W+3)'(TWO_THIRDS - t1_q[i]) * (W+3)'(6);
        fac_d[i] = six_t[W-1:0];
      end else begin
        seg_d[i] = SEG_LOW;
        fac_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l_o        <= l1_q;
    s_o        <= s1_q;
    low_half_o <= low_half_d;
    prod_o     <= prod_d;
    seg_o      <= seg_d;
    fac_o      <= fac_d;
  end

endmodule

`default_nettype wire

>>> design/hslrgb_qp.sv
// Stage 3: forms q, p and the ramp span d = q - p.
`default_nettype none

module hslrgb_qp #(
  parameter int unsigned FRAC_BITS = hslrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  hslrgb_pkg::ctl_t                                ctl_i,
  input  logic [FRAC_BITS:0]                              l_i,
  input  logic [FRAC_BITS:0]                              s_i,
  input  logic                                            low_half_i,
  input  logic [2*FRAC_BITS+2:0]                          prod_i,
  input  hslrgb_pkg::seg_e [hslrgb_pkg::CH_N-1:0]         seg_i,
  input  logic [hslrgb_pkg::CH_N-1:0][FRAC_BITS:0]        fac_i,
  output hslrgb_pkg::ctl_t                                ctl_o,
  output logic [FRAC_BITS:0]                              l_o,
  output logic [FRAC_BITS:0]                              p_o,
  output logic [FRAC_BITS:0]                              q_o,
  output logic [FRAC_BITS:0]                              d_o,
  output hslrgb_pkg::seg_e [hslrgb_pkg::CH_N-1:0]         seg_o,
  output logic [hslrgb_pkg::CH_N-1:0][FRAC_BITS:0]        fac_o
);
  import hslrgb_pkg::*;

  localparam int unsigned W  = FRAC_BITS + 1;
  localparam int unsigned XW = FRAC_BITS + 3;

  logic [XW-1:0] prod_sh;
  logic [XW-1:0] q_hi;
  logic [XW-1:0] p_diff;
  logic [W-1:0]  q_d, p_d, d_d;

  // q from the product, then p = 2l - q floored at zero
  always_comb begin
    prod_sh = prod_i[2*FRAC_BITS+2:FRAC_BITS];
    q_hi    = XW'(l_i) + XW'(s_i) - prod_sh;
    q_d     = low_half_i ? prod_sh[W-1:0] : q_hi[W-1:0];
    p_diff  = (XW'(l_i) << 1) - XW'(q_d);
    p_d     = p_diff[XW-1] ? '0 : p_diff[W-1:0];
    d_d     = (q_d >= p_d) ? (q_d - p_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    l_o   <= l_i;
    p_o   <= p_d;
    q_o   <= q_d;
    d_o   <= d_d;
    seg_o <= seg_i;
    fac_o <= fac_i;
  end

  // q never falls below p for any valid transaction
  a_q_ge_p: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.valid |-> (q_o >= p_o))
    else $error("q below p");

endmodule

`default_nettype wire

>>> design/hslrgb_chan.sv
// One color channel: ramp product, segment select and 8-bit scaling.
`default_nettype none

module hslrgb_chan #(
  parameter int unsigned FRAC_BITS = hslrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hslrgb_pkg::ctl_t                  ctl_i,
  input  hslrgb_pkg::seg_e                  seg_i,
  input  logic [FRAC_BITS:0]                fac_i,
  input  logic [FRAC_BITS:0]                l_i,
  input  logic [FRAC_BITS:0]                p_i,
  input  logic [FRAC_BITS:0]                q_i,
  input  logic [FRAC_BITS:0]                d_i,
  output logic                              valid_o,
  output logic [hslrgb_pkg::OUT_W-1:0]      value_o
);
  import hslrgb_pkg::*;

  localparam int unsigned W     = FRAC_BITS + 1;
  localparam int unsigned SW    = FRAC_BITS + 3;
  localparam int unsigned ONE_I = 1 << FRAC_BITS;
  localparam logic [W-1:0] ONE  = W'(ONE_I);

  // Stage 4: d times the ramp factor
  ctl_t          ctl4_q;
  seg_e          seg4_q;
  logic [W-1:0]  l4_q, p4_q, q4_q;
  logic [2*W-1:0] prod4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else begin
      ctl4_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    seg4_q  <= seg_i;
    l4_q    <= l_i;
    p4_q    <= p_i;
    q4_q    <= q_i;
    prod4_q <= (2*W)'(d_i) * (2*W)'(fac_i);
  end

  // Stage 5: pick the segment value (l when grey), clamp to 0..ONE
  logic [SW-1:0] ramp_sum;
  logic [SW-1:0] chan_raw;
  logic [W-1:0]  chan_d;
  logic          valid5_q;
  logic [W-1:0]  chan5_q;

  always_comb begin
    ramp_sum = SW'(p4_q) + SW'(prod4_q[2*W-1:FRAC_BITS]);
    unique case (seg4_q)
      SEG_RISE: chan_raw = ramp_sum;
      SEG_HIGH: chan_raw = SW'(q4_q);
      SEG_FALL: chan_raw = ramp_sum;
      SEG_LOW:  chan_raw = SW'(p4_q);
      default:  chan_raw = SW'(p4_q);
    endcase
    if (ctl4_q.grey) begin
      chan_d = l4_q;
    end else if (chan_raw > SW'(ONE)) begin
      chan_d = ONE;
    end else begin
      chan_d = chan_raw[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid5_q <= 1'b0;
    end else begin
      valid5_q <= ctl4_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    chan5_q <= chan_d;
  end

  // Stage 6: times 255 as (v << 8) - v, truncate, saturate
  logic [W+7:0] scaled;
  logic [8:0]   byte_w;
  logic [OUT_W-1:0] byte_d;

  always_comb begin
    scaled = ((W+8)'(chan5_q) << 8) - (W+8)'(chan5_q);
    byte_w = scaled[W+7:FRAC_BITS];
    byte_d = byte_w[8] ? {OUT_W{1'b1}} : byte_w[OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_o <= byte_d;
  end

endmodule

`default_nettype wire
